/* rtl/lis_pkg.sv */
package lis_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned VALUE_W     = 31;
  localparam int unsigned OUT_LEN_W   = 11;

  // Request payload as it travels down the row of cells.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               clr;   // table is being emptied by this request
    logic               done;  // position already found upstream
    logic               app;   // request was appended to the table
  } item_t;

endpackage

/* rtl/lis_cell.sv */
module lis_cell #(
  parameter int unsigned LEN_W = 11,
  parameter int unsigned IDX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                i_valid,
  input  lis_pkg::item_t      i_item,
  input  logic [LEN_W-1:0]    i_here,
  output logic                o_valid,
  output lis_pkg::item_t      o_item,
  output logic [LEN_W-1:0]    o_here
);

  localparam logic [LEN_W-1:0] HERE = LEN_W'(IDX + 1);

  logic [lis_pkg::VALUE_W-1:0] tail;
  logic [lis_pkg::VALUE_W-1:0] tail_next;
  logic                        occ;
  logic                        occ_next;
  lis_pkg::item_t              item_next;
  logic [LEN_W-1:0]            here_next;
  logic                        empty;

  always_comb begin
    tail_next = tail;
    occ_next  = occ;
    item_next = i_item;
    here_next = i_here;
    empty     = i_item.clr || !occ;
    if (i_valid) begin
      if (!i_item.done) begin
        if (empty) begin
          // First free slot with every tail above it smaller: append here.
          tail_next      = i_item.value;
          occ_next       = 1'b1;
          item_next.done = 1'b1;
          item_next.app  = 1'b1;
          here_next      = HERE;
        end else if (tail >= i_item.value) begin
          // Lower bound found; an equal tail is rewritten with the same value.
          tail_next      = i_item.value;
          item_next.done = 1'b1;
          here_next      = HERE;
        end
      end else if (i_item.clr) begin
        occ_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      occ     <= occ_next;
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail   <= tail_next;
      o_item <= item_next;
      o_here <= here_next;
    end
  end

endmodule

/* rtl/lis_out.sv */
module lis_out #(
  parameter int unsigned MAX_LEN = lis_pkg::MAX_LEN_DEF,
  parameter int unsigned LEN_W   = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            i_valid,
  input  lis_pkg::item_t                  i_item,
  input  logic [LEN_W-1:0]                i_here,
  output logic                            adv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lis_pkg::OUT_LEN_W-1:0]   length_here,
  output logic [lis_pkg::OUT_LEN_W-1:0]   best_length,
  output logic                            overflow
);

  localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_LEN);

  logic [LEN_W-1:0] best;
  logic [LEN_W-1:0] best_next;
  logic [LEN_W-1:0] here_fin;

  assign adv = !out_valid || out_ready;

  always_comb begin
    best_next = (i_item.clr ? '0 : best) + LEN_W'(i_item.app);
    // A request that passed every cell without settling hit a full table.
    here_fin  = i_item.done ? i_here : FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= i_valid;
      if (i_valid) begin
        best <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      length_here <= lis_pkg::OUT_LEN_W'(here_fin);
      best_length <= lis_pkg::OUT_LEN_W'(best_next);
      overflow    <= !i_item.done;
    end
  end

endmodule

/* rtl/lis_length_tracker.sv */
// Channel  Handshake            Payload
// input    in_valid / in_ready  value, start_new
// output   out_valid / out_ready length_here, best_length, overflow
//
// One request enters per cycle unless the output stalls; each walks the row of MAX_LEN tail
// cells, one cell a cycle while not stalled, and its result is then registered in lis_out.
// Requests behind one another see the table exactly as the earlier ones left it.
// Reset clears the occupancy bit of every cell and the best length at once.
// A stalled output freezes the whole row; in_ready is low only while it is stalled.
module lis_length_tracker #(
  parameter int unsigned MAX_LEN = lis_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lis_pkg::VALUE_W-1:0]         value,
  input  logic                                start_new,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lis_pkg::OUT_LEN_W-1:0]       length_here,
  output logic [lis_pkg::OUT_LEN_W-1:0]       best_length,
  output logic                                overflow
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  logic                 adv;
  logic                 v_chain    [0:MAX_LEN];
  lis_pkg::item_t       item_chain [0:MAX_LEN];
  logic [LEN_W-1:0]     here_chain [0:MAX_LEN];

  assign in_ready = adv;

  always_comb begin
    v_chain[0]         = in_valid && adv;
    item_chain[0].value = value;
    item_chain[0].clr   = start_new;
    item_chain[0].done  = 1'b0;
    item_chain[0].app   = 1'b0;
    here_chain[0]       = '0;
  end

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lis_cell #(
      .LEN_W (LEN_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .i_valid (v_chain[g]),
      .i_item  (item_chain[g]),
      .i_here  (here_chain[g]),
      .o_valid (v_chain[g+1]),
      .o_item  (item_chain[g+1]),
      .o_here  (here_chain[g+1])
    );
  end

  lis_out #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .i_valid     (v_chain[MAX_LEN]),
    .i_item      (item_chain[MAX_LEN]),
    .i_here      (here_chain[MAX_LEN]),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .length_here (length_here),
    .best_length (best_length),
    .overflow    (overflow)
  );

endmodule

/* rtl/lis_checker.sv */
module lis_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lis_pkg::OUT_LEN_W-1:0]     length_here,
  input logic [lis_pkg::OUT_LEN_W-1:0]     best_length,
  input logic                              overflow
);

  // A stalled result must be held.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(length_here) && $stable(best_length))
    else $error("stalled result changed");

  // Lengths are never zero on a delivered result.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length_here != '0) && (best_length != '0))
    else $error("zero length reported");

  // A subsequence ending here can be no longer than the best so far.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length_here <= best_length)
    else $error("length_here above best_length");

  // A refused append reports the full table length.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> length_here == best_length)
    else $error("overflow with inconsistent lengths");

  // Requests are refused only while a result is held back.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("request refused without a stall");

endmodule

bind lis_length_tracker lis_checker u_lis_checker (.*);

/* dv/tb_lis_length_tracker.sv */
module tb_lis_length_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned        VALUE_W      = lis_pkg::VALUE_W;
  localparam int unsigned        OUT_LEN_W    = lis_pkg::OUT_LEN_W;
  localparam int unsigned        TAB_DEPTH    = lis_pkg::MAX_LEN_DEF;
  localparam logic [VALUE_W-1:0] TOP_VALUE    = 31'h7FFF_FFFE;
  localparam int unsigned        CYCLE_LIMIT  = 2000000;
  localparam int unsigned        DRAIN_CYCLES = TAB_DEPTH + 64;
  localparam int unsigned        RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] here;
    logic [OUT_LEN_W-1:0] best;
    logic                 ovf;
  } lis_result_t;

  // Keeps its own table of smallest tails and the lengths each request should report.
  class lis_scoreboard;
    logic [VALUE_W-1:0] tails [TAB_DEPTH];
    int unsigned        filled;
    lis_result_t        awaited [$];
    int unsigned        errors;

    function new();
      filled = 0;
      errors = 0;
    endfunction

    function void note_request(logic [VALUE_W-1:0] v, logic clr);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lis_result_t r;
      if (clr) filled = 0;
      lo = 0;
      hi = filled;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tails[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      r.ovf = 1'b0;
      if (lo < filled) begin
        // An equal tail leaves the table untouched.
        if (tails[lo] > v) tails[lo] = v;
        r.here = OUT_LEN_W'(lo + 1);
      end else if (filled < TAB_DEPTH) begin
        tails[filled] = v;
        filled++;
        r.here = OUT_LEN_W'(filled);
      end else begin
        r.here = OUT_LEN_W'(TAB_DEPTH);
        r.ovf  = 1'b1;
      end
      r.best = OUT_LEN_W'(filled);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [OUT_LEN_W-1:0] here, logic [OUT_LEN_W-1:0] best,
                               logic ovf);
      lis_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding: length_here=%0d best_length=%0d",
                 $time, here, best);
        $display("%0t: overflow=%0b", $time, ovf);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (here !== e.here) begin
        $display("%0t: length_here expected %0d actual %0d", $time, e.here, here);
        errors++;
      end
      if (best !== e.best) begin
        $display("%0t: best_length expected %0d actual %0d", $time, e.best, best);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VALUE_W-1:0]   value = '0;
  logic                 start_new = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_LEN_W-1:0] length_here;
  logic [OUT_LEN_W-1:0] best_length;
  logic                 overflow;

  lis_scoreboard sb = new();
  bit            no_idle = 1'b0;
  int unsigned   sent = 0;
  int unsigned   cycles = 0;

  lis_length_tracker #(
    .MAX_LEN(TAB_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .start_new(start_new),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .length_here(length_here),
    .best_length(best_length),
    .overflow(overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lis_length_tracker");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(value, start_new);
    if (!rst && out_valid && out_ready) sb.check_result(length_here, best_length, overflow);
  end

  // Mostly no gap, some short ones and the odd long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return TOP_VALUE;
    return VALUE_W'($urandom_range(0, TOP_VALUE));
  endfunction

  // Returns in the step of acceptance with in_valid still high, so that a following request
  // with no gap keeps it high without a glitch.
  task automatic send_request(input logic [VALUE_W-1:0] v, input logic clr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    start_new <= clr;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int run;
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned        goal;
    int                 kind;
    int                 len;
    int                 i;
    int unsigned        step;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] first_v;
    bit                 ramp_done;
    bit                 mid_paused;

    ramp_done  = 1'b0;
    mid_paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the first request meets an empty table without a start flag.
    send_request(31'd5, 1'b0);
    send_request(31'd5, 1'b0);           // equal tail
    send_request(31'd3, 1'b0);           // replaces a larger tail
    send_request(31'd7, 1'b0);
    send_request(31'd7, 1'b0);
    send_request(31'd0, 1'b0);
    send_request(TOP_VALUE, 1'b0);
    send_request(TOP_VALUE, 1'b0);
    send_request(31'd1, 1'b0);           // lands in the middle of the table
    send_request(TOP_VALUE, 1'b1);       // start flag on a non-empty table
    send_request(31'd0, 1'b0);
    send_request(31'd0, 1'b1);
    send_request(31'd0, 1'b0);
    send_request(31'h5555_5555, 1'b1);
    send_request(31'h2AAA_AAAA, 1'b0);
    send_request(31'h5555_5555, 1'b0);
    send_request(31'h7FFF_FFFD, 1'b0);
    send_request(31'h2AAA_AAAB, 1'b0);
    pause_until_drained();

    // The fill of the whole table counts towards the total.
    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if (!ramp_done && sent + 800 >= goal) begin
        // Fill the whole table and push past it, so that appends are refused.
        no_idle = 1'b0;
        v = VALUE_W'($urandom_range(1, 1000));
        first_v = v;
        send_request(v, 1'b1);
        for (i = 1; i < TAB_DEPTH + 4; i++) begin
          v = v + VALUE_W'($urandom_range(1, 1000000));
          send_request(v, 1'b0);
        end
        send_request(first_v, 1'b0);
        send_request(v + 31'd1, 1'b0);
        send_request(31'd0, 1'b0);
        send_request(v + 31'd2, 1'b0);
        ramp_done = 1'b1;
      end
      if (!mid_paused && sent + 450 >= goal) begin
        pause_until_drained();
        mid_paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          // Mostly rising run with steps of zero for equal tails and the odd drop.
          v = VALUE_W'($urandom_range(0, 1000));
          send_request(v, 1'b1);
          len = $urandom_range(1, 60);
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              step = $urandom_range(0, 200);
              v = (v > step) ? v - VALUE_W'(step) : '0;
            end else begin
              v = v + VALUE_W'($urandom_range(0, 50));
            end
            send_request(v, 1'b0);
          end
        end
        3, 4: begin
          send_request(rand_value(), 1'b1);
          len = $urandom_range(1, 40);
          for (i = 0; i < len; i++) send_request(rand_value(), 1'b0);
        end
        5, 6: begin
          send_request(VALUE_W'($urandom_range(0, 15)), 1'b1);
          len = $urandom_range(1, 40);
          for (i = 0; i < len; i++) send_request(VALUE_W'($urandom_range(0, 15)), 1'b0);
        end
        7: begin
          v = rand_value();
          send_request(v, 1'b1);
          len = $urandom_range(1, 30);
          for (i = 0; i < len; i++) begin
            step = $urandom_range(0, 100000);
            v = (v > step) ? v - VALUE_W'(step) : '0;
            send_request(v, 1'b0);
          end
        end
        default: begin
          len = $urandom_range(1, 8);
          for (i = 0; i < len; i++) send_request(rand_value(), ($urandom_range(0, 3) == 0));
        end
      endcase
    end

    in_valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS lis_length_tracker");
    end else begin
      $display("FAIL lis_length_tracker");
    end
    $finish;
  end

endmodule
